// ----- design/vtfcs_pkg.sv -----
// Shared constants, codes and helper functions for the virtual-time class scheduler.
package vtfcs_pkg;

  localparam int TimeW     = 32;
  localparam int CountW    = 16;
  localparam int SliceW    = 16;
  localparam int PrioRegW  = 48;
  localparam int PrioW     = 3;
  localparam int WeightW   = 7;
  localparam int CidW      = 4;
  localparam int OpW       = 2;
  localparam int StatusW   = 2;
  localparam int CfgIdxW   = 1;
  localparam int PrioClasses = PrioRegW / PrioW;

  localparam logic [CountW-1:0]  CountMax = '1;
  localparam logic [WeightW-1:0] RatioMax = 7'd100;

  // request operations
  localparam logic [OpW-1:0] OP_ARRIVE   = 2'd0;
  localparam logic [OpW-1:0] OP_COMPLETE = 2'd1;
  localparam logic [OpW-1:0] OP_SCHED    = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_SATURATE = 2'd1;
  localparam logic [StatusW-1:0] ST_UNDERRUN = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SLICE_TICKS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_PRIORITIES  = 1'b1;

  // a is strictly after b, modulo 2^32
  function automatic logic time_later(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = a - b;
    return (d != '0) && !d[TimeW-1];
  endfunction

  function automatic logic [WeightW-1:0] prio_weight(input logic [PrioW-1:0] p);
    logic [WeightW-1:0] w;
    unique case (p)
      3'd0: w = 7'd100;
      3'd1: w = 7'd87;
      3'd2: w = 7'd77;
      3'd3: w = 7'd70;
      3'd4: w = 7'd63;
      3'd5: w = 7'd58;
      3'd6: w = 7'd53;
      3'd7: w = 7'd50;
    endcase
    return w;
  endfunction

endpackage

// ----- design/virtual_time_fair_class_scheduler.sv -----
// Virtual-time fair class scheduler: one request in, one result out, one request at a time.
//
// Picks which of NUM_CLASSES I/O classes owns the current time slice. Each class keeps a
// 32-bit virtual time; a class with pending requests sits in the queue. An arrive or
// complete request steps through accept, multiply, update and result. A schedule request
// that makes a decision adds a winner search and a finish step after the update: the search
// walks the classes one per cycle through a single wrap-around comparator. The input side
// stalls from acceptance until the result has been handed to the output register; the output
// register holds a finished result while the next request is taken. One shared multiplier
// serves both the clamp window (slice_ticks times 100) and the charge (elapsed ticks
// times priority weight). Configuration writes are taken at any cycle, but must only be
// issued while the block is idle.
module virtual_time_fair_class_scheduler
  import vtfcs_pkg::*;
#(
  parameter int NUM_CLASSES = 16
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PrioRegW-1:0] cfg_data,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OpW-1:0]      op,
  input  logic [CidW-1:0]     class_id,
  input  logic [TimeW-1:0]    now,
  input  logic                active_in_driver,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                active_valid,
  output logic [CidW-1:0]     active_class,
  output logic                switched,
  output logic [StatusW-1:0]  status
);

  localparam int ClsW = $clog2(NUM_CLASSES);
  localparam int QcW  = $clog2(NUM_CLASSES + 1);
  localparam int ShW  = $clog2(PrioW * NUM_CLASSES);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_APPLY = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [SliceW-1:0]   slice_ticks;
  logic [PrioRegW-1:0] prio_reg;

  // per-class state
  logic [TimeW-1:0]  vt      [NUM_CLASSES];
  logic [CountW-1:0] pend    [NUM_CLASSES];
  logic [ClsW-1:0]   rank    [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] queued;
  logic [QcW-1:0]    qcount;

  // scheduler state
  logic [TimeW-1:0] qpos;
  logic             act_valid;
  logic [ClsW-1:0]  act;
  logic [TimeW-1:0] slice_start;
  logic [TimeW-1:0] slice_stop;
  logic             slice_live;

  // captured request
  logic [OpW-1:0]   cap_op;
  logic [CidW-1:0]  cap_cid;
  logic [TimeW-1:0] cap_now;
  logic             cap_drv;

  // winner search
  logic [ClsW-1:0]  idx;
  logic             have;
  logic [ClsW-1:0]  best;
  logic [TimeW-1:0] best_vt;
  logic [ClsW-1:0]  best_rank;

  // result being built
  logic               sw;
  logic [StatusW-1:0] stat;

  // combinational
  logic               cid_ok;
  logic [ClsW-1:0]    ci;
  logic               is_sched;
  logic [ClsW-1:0]    rd_idx;
  logic [TimeW-1:0]   rd_vt;
  logic [CountW-1:0]  rd_pend;
  logic [ClsW-1:0]    rd_rank;
  logic               rd_q;
  logic [ShW-1:0]     psh;
  logic [PrioRegW-1:0] prio_sh;
  logic [PrioW-1:0]   prio;
  logic [TimeW-1:0]   mul_a;
  logic [WeightW-1:0] mul_b;
  logic [TimeW-1:0]   prod;
  logic               go;
  logic               clamp;
  logic [NUM_CLASSES-1:0] dec;
  logic               take;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign cid_ok   = 7'(cap_cid) < 7'(NUM_CLASSES);
  assign ci       = ClsW'(cap_cid);
  assign is_sched = (cap_op == OP_SCHED);

  // read mux selecting one entry of the class arrays
  always_comb begin
    if (state == S_SCAN) begin
      rd_idx = idx;
    end else if (is_sched) begin
      rd_idx = act;
    end else begin
      rd_idx = ci;
    end
  end

  assign rd_vt   = vt[rd_idx];
  assign rd_pend = pend[rd_idx];
  assign rd_rank = rank[rd_idx];
  assign rd_q    = queued[rd_idx];

  // priority of the active class; classes past the register width use priority zero
  assign psh     = ShW'(PrioW * int'(act));
  assign prio_sh = prio_reg >> psh;
  assign prio    = (7'(act) < 7'(PrioClasses)) ? prio_sh[PrioW-1:0] : '0;

  // shared multiplier operands: charge for schedule, clamp window otherwise
  assign mul_a = is_sched ? (cap_now - slice_start) : TimeW'(slice_ticks);
  assign mul_b = is_sched ? prio_weight(prio) : RatioMax;

  vtfcs_mul u_mul (
    .clk  (clk),
    .en   (state == S_MUL),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // decision needed: slice expired, nothing active, or active class gone idle
  assign go = time_later(cap_now, slice_stop) || !act_valid ||
              (!queued[act] && !cap_drv);

  // pull a class back to the queue position when it strays outside the window
  assign clamp = time_later(qpos, rd_vt + prod) || time_later(rd_vt, qpos + prod);

  // close the gap in join order left by the class being removed
  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      dec[k] = (ClsW'(k) != rd_idx) && queued[k] && (rank[k] > rd_rank);
    end
  end

  // earlier virtual time wins; equal times go to the earlier joiner
  assign take = rd_q && (!have || time_later(best_vt, rd_vt) ||
                         ((best_vt == rd_vt) && (rd_rank < best_rank)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slice_ticks <= SliceW'(25);
      prio_reg    <= '0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        vt[k]   <= '0;
        pend[k] <= '0;
        rank[k] <= '0;
      end
      queued      <= '0;
      qcount      <= '0;
      qpos        <= '0;
      act_valid   <= 1'b0;
      act         <= '0;
      slice_start <= '0;
      slice_stop  <= '0;
      slice_live  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLICE_TICKS: slice_ticks <= cfg_data[SliceW-1:0];
          CFG_PRIORITIES:  prio_reg    <= cfg_data;
          default: ;
        endcase
      end

      // raise the flag when a result is handed over, drop it once taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cap_op  <= op;
            cap_cid <= class_id;
            cap_now <= now;
            cap_drv <= active_in_driver;
            sw      <= 1'b0;
            stat    <= ST_OK;
            state   <= S_MUL;
          end
        end

        S_MUL: begin
          state <= S_APPLY;
        end

        S_APPLY: begin
          state <= S_OUT;
          if (cap_op == OP_ARRIVE && cid_ok) begin
            if (rd_pend == '0) begin
              if (clamp) begin
                vt[ci] <= qpos;
              end
              rank[ci]   <= ClsW'(qcount);
              pend[ci]   <= CountW'(1);
              queued[ci] <= 1'b1;
              qcount     <= qcount + 1'b1;
            end else if (rd_pend == CountMax) begin
              stat <= ST_SATURATE;
            end else begin
              pend[ci] <= rd_pend + 1'b1;
            end
          end else if (cap_op == OP_COMPLETE && cid_ok) begin
            if (rd_pend == '0) begin
              stat <= ST_UNDERRUN;
            end else begin
              if (rd_pend == CountW'(1)) begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                  if (dec[k]) begin
                    rank[k] <= rank[k] - 1'b1;
                  end
                end
                queued[ci] <= 1'b0;
                qcount     <= qcount - 1'b1;
              end
              pend[ci] <= rd_pend - 1'b1;
            end
          end else if (is_sched && go) begin
            // charge the outgoing class and send it to the back of the queue
            if (act_valid && slice_live) begin
              vt[act] <= rd_vt + prod;
              if (rd_q) begin
                for (int k = 0; k < NUM_CLASSES; k++) begin
                  if (dec[k]) begin
                    rank[k] <= rank[k] - 1'b1;
                  end
                end
                rank[act] <= ClsW'(qcount - 1'b1);
              end
            end
            if (qcount == '0) begin
              slice_live <= 1'b0;
            end else begin
              idx   <= '0;
              have  <= 1'b0;
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (take) begin
            have      <= 1'b1;
            best      <= idx;
            best_vt   <= rd_vt;
            best_rank <= rd_rank;
          end
          if (idx == ClsW'(NUM_CLASSES - 1)) begin
            state <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FIN: begin
          // advance the queue position to the winner's time when it is later
          if (time_later(best_vt, qpos)) begin
            qpos <= best_vt;
          end
          act_valid   <= 1'b1;
          act         <= best;
          slice_start <= cap_now;
          slice_stop  <= cap_now + TimeW'(slice_ticks);
          slice_live  <= 1'b1;
          sw          <= 1'b1;
          state       <= S_OUT;
        end

        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            active_valid <= act_valid;
            active_class <= act_valid ? CidW'(act) : '0;
            switched     <= sw;
            status       <= stat;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/vtfcs_mul.sv -----
// Shared registered multiplier: time value times a seven-bit weight, low 32 bits kept.
module vtfcs_mul
  import vtfcs_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [TimeW-1:0]   a,
  input  logic [WeightW-1:0] b,
  output logic [TimeW-1:0]   prod
);

  logic [TimeW+WeightW-1:0] full;

  assign full = (TimeW+WeightW)'(a) * (TimeW+WeightW)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[TimeW-1:0];
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the virtual-time fair class scheduler: directed table, random traffic.
`timescale 1ns / 100ps

module tb_top
  import vtfcs_pkg::*;
();

  localparam int NumClasses = 16;
  localparam int DirRows    = 22;
  localparam int Phases     = 6;
  localparam int PhaseReqs  = 310;
  localparam int StallLimit = 4000;
  localparam int SettleCycles = 30;
  // op code three is left unused by the block: it must change nothing
  localparam logic [OpW-1:0] OP_NOP = 2'd3;
  // charge per elapsed tick, indexed by the three-bit class priority
  localparam int unsigned CHARGE_WEIGHT [8] = '{100, 87, 77, 70, 63, 58, 53, 50};

  typedef struct packed {
    logic               active_valid;
    logic [CidW-1:0]    active_class;
    logic               switched;
    logic [StatusW-1:0] status;
  } sched_result_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [CidW-1:0]  cls;
    logic [TimeW-1:0] tick;
    logic             drv;
    logic             typed;  // want holds a hand-written result
    sched_result_t    want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_SLICE_TICKS;
  logic [PrioRegW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OpW-1:0]      op = OP_NOP;
  logic [CidW-1:0]     class_id = '0;
  logic [TimeW-1:0]    now = '0;
  logic                active_in_driver = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                active_valid;
  logic [CidW-1:0]     active_class;
  logic                switched;
  logic [StatusW-1:0]  status;

  // idle rates in percent per cycle, changed between phases
  int send_idle = 6;
  int recv_idle = 71;
  int fails = 0;
  int quiet_cycles = 0;

  sched_result_t expected_slices [$];
  dir_row_t      opening_reqs [DirRows];

  // shadow of the scheduler state and its two registers
  logic [TimeW-1:0]    vtime [NumClasses];
  logic [CountW-1:0]   pend  [NumClasses];
  logic [CidW-1:0]     rank  [NumClasses];
  logic [TimeW-1:0]    qpos;
  logic [TimeW-1:0]    s_start;
  logic [TimeW-1:0]    s_stop;
  logic                s_live;
  logic                act_v;
  logic [CidW-1:0]     act_cls;
  logic [SliceW-1:0]   slice_cfg;
  logic [PrioRegW-1:0] prio_cfg;

  virtual_time_fair_class_scheduler #(
    .NUM_CLASSES(NumClasses)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .class_id(class_id),
    .now(now),
    .active_in_driver(active_in_driver),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .active_valid(active_valid),
    .active_class(active_class),
    .switched(switched),
    .status(status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // a strictly after b, with the 32-bit tick counter wrapping
  function automatic logic runs_after(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = a - b;
    return (d != '0) && (d < 32'h8000_0000);
  endfunction

  function automatic int queued();
    int n;
    n = 0;
    foreach (pend[k]) begin
      if (pend[k] != '0) n++;
    end
    return n;
  endfunction

  // close the gap that class c leaves in the join order
  function automatic void rank_drop(input logic [CidW-1:0] c);
    foreach (pend[k]) begin
      if (k != c && pend[k] != '0 && rank[k] > rank[c]) rank[k] = rank[k] - 1'b1;
    end
  endfunction

  // Advance the shadow state by one request and return the result it must produce.
  function automatic sched_result_t predict_slice(input logic [OpW-1:0] rop,
                                                  input logic [CidW-1:0] c,
                                                  input logic [TimeW-1:0] t,
                                                  input logic drv);
    sched_result_t r;
    logic [TimeW-1:0] win;
    logic [TimeW-1:0] d;
    logic [CidW-1:0]  best;
    logic             have;
    logic             expired;
    logic             idle;
    int               k;
    r = '0;
    r.status = ST_OK;
    case (rop)
      OP_ARRIVE: begin
        if (pend[c] == '0) begin
          // pull a long-absent class back into the window around the queue position
          win = TimeW'(slice_cfg) * 32'd100;
          if (runs_after(qpos, vtime[c] + win) || runs_after(vtime[c], qpos + win))
            vtime[c] = qpos;
          rank[c] = CidW'(queued());
          pend[c] = CountW'(1);
        end else if (pend[c] == CountMax) begin
          r.status = ST_SATURATE;
        end else begin
          pend[c] = pend[c] + 1'b1;
        end
      end
      OP_COMPLETE: begin
        if (pend[c] == '0) begin
          r.status = ST_UNDERRUN;
        end else begin
          if (pend[c] == 1) rank_drop(c);
          pend[c] = pend[c] - 1'b1;
        end
      end
      OP_SCHED: begin
        expired = runs_after(t, s_stop);
        idle = act_v && pend[act_cls] == '0 && !drv;
        if (expired || !act_v || idle) begin
          if (act_v && s_live) begin
            // charge the outgoing class and send it to the back of the join order
            d = t - s_start;
            vtime[act_cls] = vtime[act_cls] +
                             d * CHARGE_WEIGHT[prio_cfg[PrioW*act_cls +: PrioW]];
            if (pend[act_cls] != '0) begin
              rank_drop(act_cls);
              rank[act_cls] = CidW'(queued() - 1);
            end
          end
          if (queued() == 0) begin
            s_live = 1'b0;
          end else begin
            best = '0;
            have = 1'b0;
            for (k = 0; k < NumClasses; k++) begin
              if (pend[k] != '0 && (!have || runs_after(vtime[best], vtime[k]) ||
                  (vtime[best] == vtime[k] && rank[k] < rank[best]))) begin
                best = CidW'(k);
                have = 1'b1;
              end
            end
            if (runs_after(vtime[best], qpos)) qpos = vtime[best];
            act_v = 1'b1;
            act_cls = best;
            s_start = t;
            s_stop = t + TimeW'(slice_cfg);
            s_live = 1'b1;
            r.switched = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.active_valid = act_v;
    r.active_class = act_v ? act_cls : '0;
    return r;
  endfunction

  // Offer one request after a random gap, hold it until taken, then log what must come back.
  task automatic issue_req(input logic [OpW-1:0] rop, input logic [CidW-1:0] c,
                           input logic [TimeW-1:0] t, input logic drv,
                           input logic typed, input sched_result_t want);
    sched_result_t guess;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= rop;
    class_id <= c;
    now <= t;
    active_in_driver <= drv;
    do @(posedge clk); while (in_stall !== 1'b0);
    guess = predict_slice(rop, c, t, drv);
    expected_slices.push_back(typed ? want : guess);
  endtask

  // Hold the request side until every outstanding result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load both registers on back-to-back edges; call only with the block drained.
  task automatic load_config(input logic [SliceW-1:0] slice, input logic [PrioRegW-1:0] prios);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SLICE_TICKS;
    cfg_data <= PrioRegW'(slice);
    @(posedge clk);
    cfg_index <= CFG_PRIORITIES;
    cfg_data <= prios;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_cfg = slice;
    prio_cfg = prios;
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // Compare every taken result with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_slices.size() == 0) begin
        $error("result with nothing outstanding: active_valid %0b class %0d",
               active_valid, active_class);
        fails++;
      end else begin
        want = expected_slices.pop_front();
        if (active_valid !== want.active_valid) begin
          $error("active_valid: expected %0b, got %0b", want.active_valid, active_valid);
          fails++;
        end
        if (active_class !== want.active_class) begin
          $error("active_class: expected %0d, got %0d", want.active_class, active_class);
          fails++;
        end
        if (switched !== want.switched) begin
          $error("switched: expected %0b, got %0b", want.switched, switched);
          fails++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
      end
    end
  end

  // Watchdog: give up once neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("** virtual_time_fair_class_scheduler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TimeW-1:0]    cur_now;
    logic [OpW-1:0]      rop;
    logic [CidW-1:0]     cls;
    logic [CidW-1:0]     probe;
    logic [SliceW-1:0]   slice;
    logic [PrioRegW-1:0] prios;
    logic                found;
    int                  sel;
    int                  k;

    // Hand-written results only where they are plain: empty block, errors, a no-op, first arrivals, first pick.
    //                op           cls    now            drv   typed  want
    opening_reqs = '{
      '{OP_SCHED,    4'd0,  32'd0,         1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, ST_OK}},
      '{OP_COMPLETE, 4'd3,  32'd0,         1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, ST_UNDERRUN}},
      '{OP_NOP,      4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 4'd0, 1'b0, ST_OK}},
      '{OP_ARRIVE,   4'd0,  32'd0,         1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, ST_OK}},
      '{OP_ARRIVE,   4'd15, 32'd0,         1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, ST_OK}},
      '{OP_ARRIVE,   4'd15, 32'd0,         1'b0, 1'b1, '{1'b0, 4'd0, 1'b0, ST_OK}},
      // equal times: the earlier joiner takes the first slice
      '{OP_SCHED,    4'd0,  32'd10,        1'b0, 1'b1, '{1'b1, 4'd0, 1'b1, ST_OK}},
      '{OP_SCHED,    4'd15, 32'd20,        1'b1, 1'b0, '0},
      '{OP_SCHED,    4'd0,  32'd36,        1'b1, 1'b0, '0},
      '{OP_COMPLETE, 4'd15, 32'd36,        1'b0, 1'b0, '0},
      '{OP_SCHED,    4'd0,  32'd40,        1'b0, 1'b0, '0},
      '{OP_COMPLETE, 4'd15, 32'd40,        1'b0, 1'b0, '0},
      // active class drained and idle at the top of the tick range
      '{OP_SCHED,    4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{OP_COMPLETE, 4'd0,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      // charge across the wrap, then an empty queue keeps the old owner
      '{OP_SCHED,    4'd0,  32'd5,         1'b0, 1'b0, '0},
      '{OP_SCHED,    4'd0,  32'd6,         1'b1, 1'b0, '0},
      // late joiners get clamped up to the queue position
      '{OP_ARRIVE,   4'd7,  32'd6,         1'b0, 1'b0, '0},
      '{OP_ARRIVE,   4'd8,  32'd6,         1'b0, 1'b0, '0},
      '{OP_COMPLETE, 4'd8,  32'd6,         1'b0, 1'b0, '0},
      '{OP_ARRIVE,   4'd8,  32'd7,         1'b0, 1'b0, '0},
      '{OP_SCHED,    4'd0,  32'd7,         1'b1, 1'b0, '0},
      '{OP_SCHED,    4'd0,  32'd30,        1'b1, 1'b0, '0}
    };

    foreach (vtime[i]) begin
      vtime[i] = '0;
      pend[i] = '0;
      rank[i] = '0;
    end
    qpos = '0;
    s_start = '0;
    s_stop = '0;
    s_live = 1'b0;
    act_v = 1'b0;
    act_cls = '0;
    slice_cfg = 16'd25;
    prio_cfg = '0;
    cur_now = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the opening table with the reset register values.
    for (k = 0; k < DirRows; k++) begin
      issue_req(opening_reqs[k].op, opening_reqs[k].cls, opening_reqs[k].tick,
                opening_reqs[k].drv, opening_reqs[k].typed, opening_reqs[k].want);
    end
    drain_results();
    cur_now = 32'd30;

    // Random phases: a fresh register setting each, idling swapped between the first two pairs, off in the last.
    for (int ph = 0; ph < Phases; ph++) begin
      if (ph < 2) begin
        send_idle = 6;
        recv_idle = 71;
      end else if (ph < 4) begin
        send_idle = 71;
        recv_idle = 6;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (ph)
        0: begin
          slice = 16'd1;
          prios = '0;
        end
        1: begin
          slice = 16'hFFFF;
          prios = '1;
        end
        2: begin
          slice = 16'd25;
          prios = PrioRegW'({$urandom(), $urandom()});
        end
        4: begin
          slice = 16'd3;
          prios = 48'o1234_5670_7654_3210;
        end
        default: begin
          slice = SliceW'($urandom_range(1, 400));
          prios = PrioRegW'({$urandom(), $urandom()});
        end
      endcase
      load_config(slice, prios);

      for (int n = 0; n < PhaseReqs; n++) begin
        // mostly creep forward around the slice length, now and then leap anywhere
        if ($urandom_range(0, 99) < 4) cur_now = $urandom();
        else cur_now = cur_now + $urandom_range(0, 2 * slice_cfg + 1);
        cls = CidW'($urandom_range(0, NumClasses - 1));
        sel = $urandom_range(0, 99);
        if (sel < 36) begin
          rop = OP_ARRIVE;
        end else if (sel < 64) begin
          rop = OP_COMPLETE;
          // most completions hit a queued class; the rest may find a zero count
          if (sel < 61) begin
            found = 1'b0;
            for (k = 0; k < NumClasses; k++) begin
              probe = cls + CidW'(k);
              if (!found && pend[probe] != '0) begin
                cls = probe;
                found = 1'b1;
              end
            end
          end
        end else if (sel < 96) begin
          rop = OP_SCHED;
        end else begin
          rop = OP_NOP;
        end
        issue_req(rop, cls, cur_now, 1'($urandom_range(0, 1)), 1'b0, '0);
        // now and then hold the sender until the block has emptied
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      drain_results();
    end

    // let any stray result surface before the verdict
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0) begin
      $display("** virtual_time_fair_class_scheduler: PASSED **");
    end else begin
      $display("** virtual_time_fair_class_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
